/* rtl/rrts_pkg.sv */
// Shared types, widths and codes of the round-robin thread scheduler.
package rrts_pkg;

  localparam int MaxThreads = 16;
  localparam int SlotW      = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int CntW       = $clog2(MaxThreads + 1);
  localparam int CmpW       = (CntW > 4) ? CntW : 4;
  localparam int QDepth     = 2;
  localparam int QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW      = $clog2(QDepth + 1);

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [CmpW-1:0]  cmp_t;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_EXIT   = 2'd1,
    OP_JOIN   = 2'd2,
    OP_YIELD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_RUNNING    = 2'd0,
    ST_JOINING    = 2'd1,
    ST_TERMINATED = 2'd2,
    ST_DELETED    = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  // One slot record: scheduling state and joiner bookkeeping.
  typedef struct packed {
    state_e st;
    logic   jv;
    slot_t  js;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  typedef struct packed {
    op_e        op;
    logic [3:0] target;
  } cmd_t;

endpackage

/* rtl/rrts_ram.sv */
// Generic single-port RAM with registered read.
module rrts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic                                     we_i,
  input  logic [Width-1:0]                         wdata_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/rrts_front.sv */
// Front end: accepts input items, decodes them and queues commands.
module rrts_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [3:0]          target_thread_i,
  output logic                cmd_valid_o,
  output rrts_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  rrts_pkg::cmd_t                   q_mem_q [rrts_pkg::QDepth];
  logic [rrts_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rrts_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rrts_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             push;
  logic                             pop;
  rrts_pkg::cmd_t                   cmd_in;

  assign in_stall_o  = (cnt_q == rrts_pkg::QCntW'(rrts_pkg::QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    cmd_in.op     = rrts_pkg::op_e'(operation_i);
    cmd_in.target = target_thread_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == rrts_pkg::QPtrW'(rrts_pkg::QDepth - 1)) ? '0 :
                 wr_ptr_q + rrts_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == rrts_pkg::QPtrW'(rrts_pkg::QDepth - 1)) ? '0 :
                 rd_ptr_q + rrts_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + rrts_pkg::QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - rrts_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* rtl/rrts_back.sv */
// Back end: executes commands against the slot table and holds the result.
module rrts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  rrts_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          running_thread_o,
  output logic [3:0]          created_slot_o,
  output logic [15:0]         freed_mask_o,
  output logic [1:0]          status_o
);

  typedef enum logic [10:0] {
    S_IDLE        = 11'b000_0000_0001,
    S_EXIT_RD     = 11'b000_0000_0010,
    S_EXIT_WR     = 11'b000_0000_0100,
    S_WAKE_RD     = 11'b000_0000_1000,
    S_WAKE_WR     = 11'b000_0001_0000,
    S_JOIN_RD     = 11'b000_0010_0000,
    S_JOIN_CHK    = 11'b000_0100_0000,
    S_JOIN_CUR_RD = 11'b000_1000_0000,
    S_JOIN_CUR_WR = 11'b001_0000_0000,
    S_SCAN_RD     = 11'b010_0000_0000,
    S_SCAN_EV     = 11'b100_0000_0000
  } fsm_e;

  fsm_e                  state_q, state_d;
  rrts_pkg::slot_t       cur_q, cur_d;
  rrts_pkg::cnt_t        count_q, count_d;
  rrts_pkg::slot_t       addr_q, addr_d;
  logic                  rec0_q, rec0_d;
  logic                  out_valid_q, out_valid_d;
  logic [3:0]            running_q, running_d;
  logic [3:0]            new_q, new_d;
  logic [15:0]           freed_q, freed_d;
  rrts_pkg::status_e     status_q, status_d;

  rrts_pkg::slot_t       ram_addr;
  logic                  ram_we;
  rrts_pkg::rec_t        ram_wdata;
  logic [rrts_pkg::RecW-1:0] ram_rdata;
  rrts_pkg::rec_t        view;
  rrts_pkg::slot_t       next_of_cur;
  rrts_pkg::slot_t       next_of_addr;
  logic                  finish;
  logic                  join_ok;

  rrts_ram #(
    .Width (rrts_pkg::RecW),
    .Depth (rrts_pkg::MaxThreads)
  ) u_table (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  function automatic rrts_pkg::slot_t next_slot(rrts_pkg::slot_t s, rrts_pkg::cnt_t cnt);
    rrts_pkg::cnt_t inc;
    inc = rrts_pkg::cnt_t'(s) + rrts_pkg::cnt_t'(1);
    return (inc >= cnt) ? '0 : rrts_pkg::slot_t'(inc);
  endfunction

  assign next_of_cur  = next_slot(cur_q, count_q);
  assign next_of_addr = next_slot(addr_q, count_q);

  // Slots at or above the count were never created; slot zero reads as
  // running until its record is first written.
  always_comb begin
    view = rrts_pkg::rec_t'(ram_rdata);
    if (rrts_pkg::cnt_t'(addr_q) >= count_q) begin
      view = '{st: rrts_pkg::ST_DELETED, jv: 1'b0, js: '0};
    end else if ((addr_q == '0) && !rec0_q) begin
      view = '{st: rrts_pkg::ST_RUNNING, jv: 1'b0, js: '0};
    end
  end

  assign join_ok = (rrts_pkg::cmp_t'(cmd_i.target) < rrts_pkg::cmp_t'(count_q)) &&
                   (rrts_pkg::cmp_t'(cmd_i.target) != rrts_pkg::cmp_t'(cur_q));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    count_d     = count_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q;
    running_d   = running_q;
    new_d       = new_q;
    freed_d     = freed_q;
    status_d    = status_q;
    ram_addr    = addr_q;
    ram_we      = 1'b0;
    ram_wdata   = view;
    cmd_pop_o   = 1'b0;
    finish      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          new_d     = '0;
          freed_d   = '0;
          status_d  = rrts_pkg::STAT_OK;
          case (cmd_i.op)
            rrts_pkg::OP_CREATE: begin
              if (count_q == rrts_pkg::cnt_t'(rrts_pkg::MaxThreads)) begin
                status_d = rrts_pkg::STAT_FULL;
              end else begin
                ram_addr  = rrts_pkg::slot_t'(count_q);
                ram_we    = 1'b1;
                ram_wdata = '{st: rrts_pkg::ST_RUNNING, jv: 1'b0, js: '0};
                new_d     = 4'(count_q);
                count_d   = count_q + rrts_pkg::cnt_t'(1);
              end
              finish = 1'b1;
            end
            rrts_pkg::OP_EXIT: begin
              addr_d  = cur_q;
              state_d = S_EXIT_RD;
            end
            rrts_pkg::OP_JOIN: begin
              if (join_ok) begin
                addr_d  = rrts_pkg::slot_t'(cmd_i.target);
                state_d = S_JOIN_RD;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              addr_d  = next_of_cur;
              state_d = S_SCAN_RD;
            end
          endcase
        end
      end
      S_EXIT_RD: begin
        state_d = S_EXIT_WR;
      end
      S_EXIT_WR: begin
        ram_we       = 1'b1;
        ram_wdata.st = rrts_pkg::ST_TERMINATED;
        if (view.jv) begin
          addr_d  = view.js;
          state_d = S_WAKE_RD;
        end else begin
          addr_d  = next_of_cur;
          state_d = S_SCAN_RD;
        end
      end
      S_WAKE_RD: begin
        state_d = S_WAKE_WR;
      end
      S_WAKE_WR: begin
        if (view.st == rrts_pkg::ST_JOINING) begin
          ram_we       = 1'b1;
          ram_wdata.st = rrts_pkg::ST_RUNNING;
        end
        addr_d  = next_of_cur;
        state_d = S_SCAN_RD;
      end
      S_JOIN_RD: begin
        state_d = S_JOIN_CHK;
      end
      S_JOIN_CHK: begin
        if ((view.st == rrts_pkg::ST_TERMINATED) || (view.st == rrts_pkg::ST_DELETED)) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_we       = 1'b1;
          ram_wdata.jv = 1'b1;
          ram_wdata.js = cur_q;
          addr_d       = cur_q;
          state_d      = S_JOIN_CUR_RD;
        end
      end
      S_JOIN_CUR_RD: begin
        state_d = S_JOIN_CUR_WR;
      end
      S_JOIN_CUR_WR: begin
        ram_we       = 1'b1;
        ram_wdata.st = rrts_pkg::ST_JOINING;
        addr_d       = next_of_cur;
        state_d      = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (addr_q == cur_q) begin
          // Back around to the current slot: nothing else was runnable.
          status_d = (view.st == rrts_pkg::ST_RUNNING) ? rrts_pkg::STAT_OK :
                                                         rrts_pkg::STAT_NONE;
          finish   = 1'b1;
          state_d  = S_IDLE;
        end else if (view.st == rrts_pkg::ST_RUNNING) begin
          cur_d   = addr_q;
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (view.st == rrts_pkg::ST_TERMINATED) begin
            ram_we       = 1'b1;
            ram_wdata.st = rrts_pkg::ST_DELETED;
            if (32'(addr_q) < 32'd16) begin
              freed_d = freed_q | (16'(1) << addr_q);
            end
          end
          addr_d  = next_of_addr;
          state_d = S_SCAN_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_d = 1'b1;
      running_d   = 4'(cur_d);
    end
  end

  assign rec0_d = rec0_q || (ram_we && (ram_addr == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      count_q     <= rrts_pkg::cnt_t'(1);
      addr_q      <= '0;
      rec0_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      rec0_q      <= rec0_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    running_q <= running_d;
    new_q     <= new_d;
    freed_q   <= freed_d;
    status_q  <= status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign running_thread_o = running_q;
  assign created_slot_o   = new_q;
  assign freed_mask_o     = freed_q;
  assign status_o         = status_q;

endmodule

/* rtl/round_robin_thread_scheduler.sv */
// Top level of the round-robin thread scheduler: front queue plus executor.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | operation_i, target_thread_i
//  out     | output    | out_valid_o / out_stall_i  | running_thread_o, created_slot_o,
//          |           |                            | freed_mask_o, status_o
//
// Create, a full table and out-of-range or self joins finish in S_IDLE, a join on a
// finished target in S_JOIN_CHK; otherwise exit passes S_EXIT_RD/WR (and S_WAKE_RD/WR
// if a joiner waits) and join S_JOIN_RD/CHK/CUR_RD/CUR_WR before the scan, which visits
// each slot (single port slot table: read in S_SCAN_RD, then evaluate and write back).
// One item executes at a time; a 2-entry command queue keeps accepting while the
// executor works or a result waits. After reset slot 0 runs and the table needs
// no clearing pass. in_stall_o rises only when the command queue is full.
module round_robin_thread_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  target_thread_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  running_thread_o,
  output logic [3:0]  created_slot_o,
  output logic [15:0] freed_mask_o,
  output logic [1:0]  status_o
);

  logic           cmd_valid;
  rrts_pkg::cmd_t cmd;
  logic           cmd_pop;

  rrts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .target_thread_i (target_thread_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  rrts_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .running_thread_o (running_thread_o),
    .created_slot_o   (created_slot_o),
    .freed_mask_o     (freed_mask_o),
    .status_o         (status_o)
  );

endmodule
